// ===== rtl/core/pds_pkg.sv =====
`timescale 1ns / 1ps

package pds_pkg;

   localparam int NumDomains = 5;
   localparam int RspDepth   = 4;
   localparam int RspPtrW    = $clog2(RspDepth);
   localparam int RspCntW    = $clog2(RspDepth + 1);

   // command codes
   localparam logic [1:0] CmdStart = 2'd0;
   localparam logic [1:0] CmdQuery = 2'd1;
   localparam logic [1:0] CmdTick  = 2'd2;

   // status codes
   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StInvalid = 2'd1;
   localparam logic [1:0] StTimeout = 2'd2;
   localparam logic [1:0] StBusy    = 2'd3;

   // sequencer phases
   localparam logic [1:0] PhIdle = 2'd0;
   localparam logic [1:0] PhPwr  = 2'd1;
   localparam logic [1:0] PhAck  = 2'd2;

   // power unit register offsets
   localparam logic [11:0] OfsReq    = 12'h110;
   localparam logic [11:0] OfsUngate = 12'h140;
   localparam logic [11:0] OfsPwr    = 12'h210;

   localparam logic [15:0] PollLimitReset = 16'd10000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  domain;
      logic [31:0] repair_word;
      logic [31:0] ack_word;
   } req_type;

   typedef struct packed {
      logic        bus_write;
      logic [11:0] write_offset;
      logic [31:0] write_data;
      logic        done_res;
      logic [1:0]  status_code;
      logic        is_on;
      logic        last;
   } rsp_type;

   // results produced by one accepted beat
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } push_type;

   typedef struct packed {
      logic [15:0] pwr;
      logic [15:0] repair;
      logic [11:0] req_ofs;
      logic [15:0] req;
      logic [31:0] idle;
      logic [15:0] ungate;
   } dom_type;

   function automatic dom_type dom_entry(input logic [2:0] d);
      dom_type e;
      e = '0;
      unique case (d)
         3'd0: e = '{16'h0040, 16'h0040, 12'h004, 16'h0004, 32'h0004_0000, 16'h0004};
         3'd1: e = '{16'h0080, 16'h0080, 12'h004, 16'h0002, 32'h0002_0000, 16'h0006};
         3'd2: e = '{16'h0100, 16'h0100, 12'h004, 16'h0001, 32'h0001_0000, 16'h0001};
         3'd3: e = '{16'h8000, 16'h8000, 12'h000, 16'h0800, 32'h0000_0800, 16'h6800};
         3'd4: e = '{16'h0800, 16'h0800, 12'h000, 16'h6000, 32'h0000_6000, 16'h6000};
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic logic dom_valid(input logic [2:0] d);
      dom_type e;
      e = dom_entry(d);
      return ({1'b0, d} < 4'(NumDomains)) && (e.pwr != 16'h0);
   endfunction

   function automatic rsp_type mk_write(input logic [11:0] ofs, input logic [15:0] mask,
                                        input logic set);
      rsp_type r;
      r = '0;
      r.bus_write    = 1'b1;
      r.write_offset = ofs;
      r.write_data   = {mask, set ? mask : 16'h0};
      return r;
   endfunction

   function automatic rsp_type mk_done(input logic [1:0] st, input logic on);
      rsp_type r;
      r = '0;
      r.done_res    = 1'b1;
      r.status_code = st;
      r.is_on       = on;
      return r;
   endfunction

endpackage

// ===== rtl/core/power_domain_on_sequencer.sv =====
`timescale 1ns / 1ps

// power-up sequencer for five fixed power domains. each req beat (start, query or one
// microsecond tick) is decoded in a single pass against the sequencer state and turns into
// zero, one or two rsp beats: register writes toward the power unit (upper 16 bits of the
// data are the write-enable mask) and a done beat with the status. the final rsp beat of a
// req beat carries last. results go through a four-entry response queue, so a req beat is
// taken every cycle while at most two results are still waiting; with rsp_ready held high
// the block sustains one req beat per cycle for single-result beats, and the output port
// (one rsp beat per cycle) sets the rate when beats produce two results. csr_wr_data sets
// the poll limit in ticks and should only be written while the sequencer is idle.
module power_domain_on_sequencer (
   input  logic               clock,
   input  logic               reset,
   // command / tick beats
   input  logic               req_valid,
   output logic               req_ready,
   input  pds_pkg::req_type   req_data,
   // write and status beats
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pds_pkg::rsp_type   rsp_data,
   // poll limit register
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic               accept;
   logic               room;
   pds_pkg::push_type  push;

   // accept whenever the queue can absorb a worst-case beat
   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   // state and single-pass decode
   pds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   // result buffer decoupling the two sides
   pds_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/pds_ctrl.sv =====
`timescale 1ns / 1ps

module pds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  pds_pkg::req_type     item,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   output pds_pkg::push_type    push
);

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  active_domain_ff, active_domain_in;
   logic [15:0] poll_count_ff, poll_count_in;
   logic [15:0] poll_limit_ff;

   pds_pkg::dom_type   cur_dom, act_dom;
   pds_pkg::push_type  step;
   logic [15:0]        count_inc;
   logic               expired;
   logic               finishing;
   logic [1:0]         finish_st;

   assign cur_dom   = pds_pkg::dom_entry(item.domain);
   assign act_dom   = pds_pkg::dom_entry(active_domain_ff);
   assign count_inc = poll_count_ff + 16'd1;
   assign expired   = count_inc >= poll_limit_ff;

   always_comb begin
      step             = '0;
      phase_in         = phase_ff;
      active_domain_in = active_domain_ff;
      poll_count_in    = poll_count_ff;
      finishing        = 1'b0;
      finish_st        = pds_pkg::StOk;
      unique case (item.cmd)
         pds_pkg::CmdStart: begin
            if (phase_ff != pds_pkg::PhIdle) begin
               step.count = 2'd1;
               step.res0  = pds_pkg::mk_done(pds_pkg::StBusy, 1'b0);
            end else if (!pds_pkg::dom_valid(item.domain)) begin
               step.count = 2'd1;
               step.res0  = pds_pkg::mk_done(pds_pkg::StInvalid, 1'b0);
            end else if ((item.repair_word[15:0] & cur_dom.repair) != 16'h0) begin
               step.count = 2'd1;
               step.res0  = pds_pkg::mk_done(pds_pkg::StOk, 1'b0);
            end else begin
               if (cur_dom.ungate != 16'h0) begin
                  step.count = 2'd2;
                  step.res0  = pds_pkg::mk_write(pds_pkg::OfsUngate, cur_dom.ungate, 1'b1);
                  step.res1  = pds_pkg::mk_write(pds_pkg::OfsPwr, cur_dom.pwr, 1'b0);
               end else begin
                  step.count = 2'd1;
                  step.res0  = pds_pkg::mk_write(pds_pkg::OfsPwr, cur_dom.pwr, 1'b0);
               end
               active_domain_in = item.domain;
               poll_count_in    = 16'h0;
               phase_in         = pds_pkg::PhPwr;
            end
         end
         pds_pkg::CmdQuery: begin
            step.count = 2'd1;
            if (!pds_pkg::dom_valid(item.domain)) begin
               step.res0 = pds_pkg::mk_done(pds_pkg::StInvalid, 1'b0);
            end else begin
               step.res0 = pds_pkg::mk_done(pds_pkg::StOk,
                  (item.repair_word[15:0] & cur_dom.repair) != 16'h0);
            end
         end
         pds_pkg::CmdTick: begin
            if (phase_ff == pds_pkg::PhPwr) begin
               if ((item.repair_word[15:0] & act_dom.repair) != 16'h0) begin
                  if (act_dom.req == 16'h0) begin
                     finishing = 1'b1;
                  end else begin
                     step.count    = 2'd1;
                     step.res0     = pds_pkg::mk_write(pds_pkg::OfsReq + act_dom.req_ofs,
                                                       act_dom.req, 1'b0);
                     poll_count_in = 16'h0;
                     phase_in      = pds_pkg::PhAck;
                  end
               end else begin
                  poll_count_in = count_inc;
                  finishing     = expired;
                  finish_st     = pds_pkg::StTimeout;
               end
            end else if (phase_ff == pds_pkg::PhAck) begin
               if ((item.ack_word & act_dom.idle) == 32'h0) begin
                  finishing = 1'b1;
               end else begin
                  poll_count_in = count_inc;
                  finishing     = expired;
                  finish_st     = pds_pkg::StTimeout;
               end
            end
         end
         default: begin
            step = '0;
         end
      endcase

      // restore the clock gate, then report
      if (finishing) begin
         if (act_dom.ungate != 16'h0) begin
            step.count = 2'd2;
            step.res0  = pds_pkg::mk_write(pds_pkg::OfsUngate, act_dom.ungate, 1'b0);
            step.res1  = pds_pkg::mk_done(finish_st, 1'b0);
         end else begin
            step.count = 2'd1;
            step.res0  = pds_pkg::mk_done(finish_st, 1'b0);
         end
         phase_in      = pds_pkg::PhIdle;
         poll_count_in = 16'h0;
      end

      // mark the final result of the beat
      if (step.count == 2'd2) begin
         step.res1.last = 1'b1;
      end else if (step.count == 2'd1) begin
         step.res0.last = 1'b1;
      end
   end

   always_comb begin
      push       = step;
      push.count = accept ? step.count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= pds_pkg::PhIdle;
         active_domain_ff <= 3'd0;
         poll_count_ff    <= 16'h0;
         poll_limit_ff    <= pds_pkg::PollLimitReset;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            active_domain_ff <= active_domain_in;
            poll_count_ff    <= poll_count_in;
         end
         if (csr_wr_en) begin
            poll_limit_ff <= csr_wr_data;
         end
      end
   end

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pds_pkg::PhIdle) |-> (poll_count_ff == 16'h0))
      else $error("poll count left nonzero while idle");

   a_pair_starts_with_write: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.res0.bus_write && !push.res0.last && push.res1.last))
      else $error("two-result beat not a write followed by the final result");

   a_busy_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && item.cmd == pds_pkg::CmdStart && phase_ff != pds_pkg::PhIdle)
      |=> (phase_ff == $past(phase_ff)))
      else $error("busy start disturbed the running sequence");

endmodule

// ===== rtl/core/pds_rsp_queue.sv =====
`timescale 1ns / 1ps

module pds_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  pds_pkg::push_type  push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pds_pkg::rsp_type   rsp_data
);

   pds_pkg::rsp_type               slot_ff [pds_pkg::RspDepth];
   logic [pds_pkg::RspPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pds_pkg::RspPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pds_pkg::RspCntW-1:0]    count_ff, count_in;
   logic                           pop;
   logic [pds_pkg::RspPtrW-1:0]    wr_ptr_nx;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   // two free slots needed for a worst-case beat
   assign room      = count_ff <= pds_pkg::RspCntW'(pds_pkg::RspDepth - 2);
   assign wr_ptr_nx = wr_ptr_ff + pds_pkg::RspPtrW'(1);

   assign wr_ptr_in = wr_ptr_ff + pds_pkg::RspPtrW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + pds_pkg::RspPtrW'(pop);
   assign count_in  = count_ff + pds_pkg::RspCntW'(push.count) - pds_pkg::RspCntW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_nx] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pds_pkg::RspCntW'(pds_pkg::RspDepth))
      else $error("response queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed without room");

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");

endmodule

// ===== bench/tb_power_domain_on_sequencer.sv =====
`timescale 1ns / 1ps

// power_domain_on_sequencer bench: table-driven directed beats, then random
// power-up sequences checked against an in-bench model of the sequencer
module tb_power_domain_on_sequencer;

   // command code the block has no name for: it must be ignored
   localparam logic [1:0] CmdNone = 2'd3;

   localparam int ClkHalf      = 6;
   localparam int ResetCycles  = 12;
   localparam int SettleCycles = 10;    // queue of four plus margin
   localparam int DrainLimit   = 3000;
   localparam int StuckLimit   = 5000;  // cycles with no beat on either side
   localparam int HoldCycles   = 300;   // long receiver hold-off
   localparam int PhaseBeats   = 130;
   localparam int NumPhases    = 7;
   localparam int MaxPrinted   = 100;

   // per-domain table, kept here independently of the rtl
   typedef struct packed {
      logic        valid;
      logic [31:0] on_mask;   // repair status bit
      logic [15:0] pwr;
      logic [11:0] req_ofs;
      logic [15:0] req;
      logic [31:0] idle;
      logic [15:0] ungate;
   } dom_info_type;

   // one directed row: a poll limit write or a req beat
   typedef struct {
      bit                   is_csr;
      logic [15:0]          csr_val;
      pds_pkg::req_type     beat;
      int                   n_typed;   // -1: expectation comes from the model
      pds_pkg::rsp_type     typed;
   } dir_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   pds_pkg::req_type   req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   pds_pkg::rsp_type   rsp_data;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   // typed expectation travelling with the current req beat
   int                 req_tag_n;
   pds_pkg::rsp_type   req_tag_rsp;

   // sequencer model state
   logic [1:0]  seq_phase;
   logic [2:0]  act_dom;
   logic [15:0] poll_cnt;
   logic [15:0] poll_lim;

   pds_pkg::rsp_type  beat_rsp[$];   // results of the beat being modeled
   pds_pkg::rsp_type  exp_rsp[$];    // results still owed by the block
   dir_row_type       dir_tab[$];

   int          err_cnt = 0;
   int          beats_sent = 0;
   int          burst_left = 0;
   int          hold_left = 0;
   int          stuck_cnt = 0;
   logic [15:0] cur_lim = pds_pkg::PollLimitReset;

   power_domain_on_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #ClkHalf clock = ~clock;
   end

   // ---------------------------------------------------------------
   // sequencer model
   // ---------------------------------------------------------------

   function automatic dom_info_type dom_info(input logic [2:0] d);
      dom_info_type e;
      e = '0;
      case (d)
         3'd0: e = '{1'b1, 32'h0000_0040, 16'h0040, 12'h004, 16'h0004, 32'h0004_0000, 16'h0004};
         3'd1: e = '{1'b1, 32'h0000_0080, 16'h0080, 12'h004, 16'h0002, 32'h0002_0000, 16'h0006};
         3'd2: e = '{1'b1, 32'h0000_0100, 16'h0100, 12'h004, 16'h0001, 32'h0001_0000, 16'h0001};
         3'd3: e = '{1'b1, 32'h0000_8000, 16'h8000, 12'h000, 16'h0800, 32'h0000_0800, 16'h6800};
         3'd4: e = '{1'b1, 32'h0000_0800, 16'h0800, 12'h000, 16'h6000, 32'h0000_6000, 16'h6000};
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic pds_pkg::rsp_type done_beat(input logic [1:0] st, input logic on);
      pds_pkg::rsp_type r;
      r = '0;
      r.done_res    = 1'b1;
      r.status_code = st;
      r.is_on       = on;
      return r;
   endfunction

   // masked write: enable mask in the upper half, data below
   function automatic void push_wr(input logic [11:0] ofs, input logic [15:0] mask,
                                   input logic set);
      pds_pkg::rsp_type r;
      r = '0;
      r.bus_write    = 1'b1;
      r.write_offset = ofs;
      r.write_data   = {mask, set ? mask : 16'h0000};
      beat_rsp.push_back(r);
   endfunction

   // put the clock gate back if the domain has one, then report
   function automatic void close_seq(input logic [1:0] st);
      dom_info_type a;
      a = dom_info(act_dom);
      if (a.ungate != '0) push_wr(pds_pkg::OfsUngate, a.ungate, 1'b0);
      beat_rsp.push_back(done_beat(st, 1'b0));
      seq_phase = pds_pkg::PhIdle;
      poll_cnt  = '0;
   endfunction

   function automatic bit poll_expired();
      poll_cnt = poll_cnt + 16'd1;
      return poll_cnt >= poll_lim;
   endfunction

   function automatic void seq_model(input pds_pkg::req_type b);
      dom_info_type e;
      dom_info_type a;
      e = dom_info(b.domain);
      a = dom_info(act_dom);
      beat_rsp.delete();
      case (b.cmd)
         pds_pkg::CmdStart: begin
            if (seq_phase != pds_pkg::PhIdle) begin
               beat_rsp.push_back(done_beat(pds_pkg::StBusy, 1'b0));
            end else if (!e.valid) begin
               beat_rsp.push_back(done_beat(pds_pkg::StInvalid, 1'b0));
            end else if ((b.repair_word & e.on_mask) != '0) begin
               // already powered, nothing to write
               beat_rsp.push_back(done_beat(pds_pkg::StOk, 1'b0));
            end else begin
               if (e.ungate != '0) push_wr(pds_pkg::OfsUngate, e.ungate, 1'b1);
               push_wr(pds_pkg::OfsPwr, e.pwr, 1'b0);
               act_dom   = b.domain;
               poll_cnt  = '0;
               seq_phase = pds_pkg::PhPwr;
            end
         end
         pds_pkg::CmdQuery: begin
            if (!e.valid) beat_rsp.push_back(done_beat(pds_pkg::StInvalid, 1'b0));
            else beat_rsp.push_back(done_beat(pds_pkg::StOk,
                                              (b.repair_word & e.on_mask) != '0));
         end
         pds_pkg::CmdTick: begin
            if (seq_phase == pds_pkg::PhPwr) begin
               if ((b.repair_word & a.on_mask) != '0) begin
                  if (a.req == '0) begin
                     close_seq(pds_pkg::StOk);
                  end else begin
                     push_wr(pds_pkg::OfsReq + a.req_ofs, a.req, 1'b0);
                     poll_cnt  = '0;
                     seq_phase = pds_pkg::PhAck;
                  end
               end else if (poll_expired()) begin
                  close_seq(pds_pkg::StTimeout);
               end
            end else if (seq_phase == pds_pkg::PhAck) begin
               if ((b.ack_word & a.idle) == '0) close_seq(pds_pkg::StOk);
               else if (poll_expired()) close_seq(pds_pkg::StTimeout);
            end else begin
               seq_phase = pds_pkg::PhIdle;
            end
         end
         default: ;
      endcase
      if (beat_rsp.size() > 0) beat_rsp[beat_rsp.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_err(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      if (err_cnt < MaxPrinted)
         $display("%0t ERROR %s: got %h want %h", $time, what, got, want);
      err_cnt++;
   endtask

   task automatic check_rsp(input pds_pkg::rsp_type got);
      pds_pkg::rsp_type want;
      if (exp_rsp.size() == 0) begin
         report_err("rsp beat with nothing pending", got.write_data, '0);
         return;
      end
      want = exp_rsp.pop_front();
      if (got.bus_write !== want.bus_write)
         report_err("bus_write", 32'(got.bus_write), 32'(want.bus_write));
      if (got.write_offset !== want.write_offset)
         report_err("write_offset", 32'(got.write_offset), 32'(want.write_offset));
      if (got.write_data !== want.write_data)
         report_err("write_data", got.write_data, want.write_data);
      if (got.done_res !== want.done_res)
         report_err("done_res", 32'(got.done_res), 32'(want.done_res));
      if (got.status_code !== want.status_code)
         report_err("status_code", 32'(got.status_code), 32'(want.status_code));
      if (got.is_on !== want.is_on)
         report_err("is_on", 32'(got.is_on), 32'(want.is_on));
      if (got.last !== want.last)
         report_err("last", 32'(got.last), 32'(want.last));
   endtask

   // everything is sampled at the rising edge, inputs only move on the falling one
   always @(posedge clock) begin
      if (reset) begin
         seq_phase = pds_pkg::PhIdle;
         act_dom   = '0;
         poll_cnt  = '0;
         poll_lim  = pds_pkg::PollLimitReset;
      end else begin
         if (req_valid && req_ready) begin
            seq_model(req_data);
            // typed rows replace the model's results, the model still tracks state
            if (req_tag_n >= 0) begin
               beat_rsp.delete();
               if (req_tag_n > 0) beat_rsp.push_back(req_tag_rsp);
            end
            foreach (beat_rsp[i]) exp_rsp.push_back(beat_rsp[i]);
         end
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
         if (csr_wr_en) poll_lim = csr_wr_data;
      end
   end

   // watchdog: no beat moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cnt = 0;
      end else begin
         stuck_cnt++;
         if (stuck_cnt >= StuckLimit) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, StuckLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: stall windows of random strength, plus a requested hold-off
   // ---------------------------------------------------------------

   initial begin
      int win;
      int pct;
      win = 0;
      pct = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (win == 0) begin
               win = $urandom_range(20, 80);
               case ($urandom_range(0, 4))
                  0, 1: pct = 0;    // no stalls at all
                  2:    pct = 25;
                  3:    pct = 60;
                  default: pct = 90;
               endcase
            end
            win--;
            rsp_ready <= ($urandom_range(0, 99) >= pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------

   function automatic pds_pkg::req_type mk_beat(input logic [1:0] cmd, input logic [2:0] d,
                                                input logic [31:0] rep,
                                                input logic [31:0] ack);
      pds_pkg::req_type b;
      b.cmd         = cmd;
      b.domain      = d;
      b.repair_word = rep;
      b.ack_word    = ack;
      return b;
   endfunction

   // bursts of random length, random gaps between them (some bursts back to back)
   task automatic send_beat(input pds_pkg::req_type b, input int tn,
                            input pds_pkg::rsp_type tr);
      int g;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            g = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= b;
      req_tag_n   <= tn;
      req_tag_rsp <= tr;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_pred(input pds_pkg::req_type b);
      send_beat(b, -1, '0);
   endtask

   // stop sending and wait for every owed result, then a few quiet cycles
   task automatic drain();
      int w;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      w = 0;
      while (exp_rsp.size() > 0 && w < DrainLimit) begin
         @(posedge clock);
         w++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // finish any running sequence so the poll limit can be changed safely
   task automatic settle_idle();
      drain();
      while (seq_phase != pds_pkg::PhIdle) begin
         send_pred(mk_beat(pds_pkg::CmdTick, '0, 32'hFFFF_FFFF, 32'h0000_0000));
         drain();
      end
   endtask

   task automatic write_limit(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_lim = v;
   endtask

   // any command, any domain, any words
   task automatic send_noise();
      send_pred(mk_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                        $urandom, $urandom));
   endtask

   // occasionally slip a query, a start while busy or an unknown command into a sequence
   task automatic maybe_interject();
      if ($urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 2))
            0: send_pred(mk_beat(pds_pkg::CmdQuery, 3'($urandom_range(0, 7)),
                                 $urandom, $urandom));
            1: send_pred(mk_beat(pds_pkg::CmdStart, 3'($urandom_range(0, 7)),
                                 $urandom, $urandom));
            default: send_pred(mk_beat(CmdNone, 3'($urandom_range(0, 7)), $urandom, $urandom));
         endcase
      end
   endtask

   // well-formed power-up: start, power poll, request release, ack poll
   task automatic run_power_up();
      logic [2:0]   d;
      dom_info_type e;
      int           nmax;
      int           n;
      logic [31:0]  w;
      d = 3'($urandom_range(0, pds_pkg::NumDomains - 1));
      e = dom_info(d);
      nmax = (cur_lim < 6) ? int'(cur_lim) + 1 : 6;
      send_pred(mk_beat(pds_pkg::CmdStart, d, $urandom & ~e.on_mask, $urandom));
      // power poll: some ticks still off, enough of them at small limits to time out
      n = $urandom_range(0, nmax);
      repeat (n) begin
         maybe_interject();
         send_pred(mk_beat(pds_pkg::CmdTick, 3'($urandom), $urandom & ~e.on_mask, $urandom));
      end
      maybe_interject();
      send_pred(mk_beat(pds_pkg::CmdTick, 3'($urandom), $urandom | e.on_mask, $urandom));
      // ack poll: some ticks with at least one idle bit still set
      n = $urandom_range(0, nmax);
      repeat (n) begin
         maybe_interject();
         w = $urandom;
         if ((w & e.idle) == '0) w = w | e.idle;
         send_pred(mk_beat(pds_pkg::CmdTick, 3'($urandom), $urandom, w));
      end
      maybe_interject();
      send_pred(mk_beat(pds_pkg::CmdTick, 3'($urandom), $urandom, $urandom & ~e.idle));
   endtask

   // ---------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------

   function automatic void add_csr(input logic [15:0] v);
      dir_row_type r;
      r.is_csr  = 1'b1;
      r.csr_val = v;
      r.beat    = '0;
      r.n_typed = -1;
      r.typed   = '0;
      dir_tab.push_back(r);
   endfunction

   function automatic void add_row(input logic [1:0] cmd, input logic [2:0] d,
                                   input logic [31:0] rep, input logic [31:0] ack,
                                   input int n, input logic [1:0] st, input logic on);
      dir_row_type r;
      r.is_csr     = 1'b0;
      r.csr_val    = '0;
      r.beat       = mk_beat(cmd, d, rep, ack);
      r.n_typed    = n;
      r.typed      = done_beat(st, on);
      r.typed.last = 1'b1;
      dir_tab.push_back(r);
   endfunction

   function automatic void build_table();
      // reset poll limit; queries and immediate answers
      add_row(pds_pkg::CmdQuery, 3'd0, 32'h0000_0000, 32'h0000_0000, 1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdQuery, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, pds_pkg::StOk, 1'b1);
      add_row(pds_pkg::CmdQuery, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1,
              pds_pkg::StInvalid, 1'b0);
      add_row(pds_pkg::CmdStart, 3'd5, 32'h0000_0000, 32'h0000_0000, 1,
              pds_pkg::StInvalid, 1'b0);
      add_row(pds_pkg::CmdStart, 3'd7, 32'h0000_0000, 32'hFFFF_FFFF, 1,
              pds_pkg::StInvalid, 1'b0);
      // already on
      add_row(pds_pkg::CmdStart, 3'd2, 32'h0000_0100, 32'h0000_0000, 1, pds_pkg::StOk, 1'b0);
      // ignored
      add_row(CmdNone, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, pds_pkg::StOk, 1'b0);
      // tick while idle
      add_row(pds_pkg::CmdTick, 3'd3, 32'hFFFF_FFFF, 32'h0000_0000, 0, pds_pkg::StOk, 1'b0);
      // full power-up of domain 0
      add_row(pds_pkg::CmdStart, 3'd0, 32'hFFFF_FFBF, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdStart, 3'd1, 32'h0000_0000, 32'h0000_0000, 1,
              pds_pkg::StBusy, 1'b0);
      // query while busy
      add_row(pds_pkg::CmdQuery, 3'd3, 32'h0000_8000, 32'h0000_0000, 1, pds_pkg::StOk, 1'b1);
      add_row(pds_pkg::CmdTick,  3'd0, 32'h0000_0000, 32'hFFFF_FFFF, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd0, 32'h0000_0040, 32'hFFFF_FFFF, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd0, 32'h0000_0000, 32'hFFFF_FFFF, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd0, 32'h0000_0000, 32'hFFFB_FFFF, -1, pds_pkg::StOk, 1'b0);
      // limit zero: first off tick times out the power poll
      add_csr(16'd0);
      add_row(pds_pkg::CmdStart, 3'd3, 32'hFFFF_7FFF, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd3, 32'h0000_0000, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      // largest limit, domain with a multi-bit request
      add_csr(16'hFFFF);
      add_row(pds_pkg::CmdStart, 3'd4, 32'hFFFF_F7FF, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd4, 32'h0000_0800, 32'hFFFF_FFFF, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd4, 32'h0000_0000, 32'hFFFF_FFFF, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd4, 32'h0000_0000, 32'hFFFF_9FFF, -1, pds_pkg::StOk, 1'b0);
      // limit one: ack poll timeout, then power poll timeout
      add_csr(16'd1);
      add_row(pds_pkg::CmdStart, 3'd1, 32'h0000_0000, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd1, 32'h0000_0080, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd1, 32'h0000_0000, 32'h0002_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdStart, 3'd2, 32'h0000_0000, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
      add_row(pds_pkg::CmdTick,  3'd2, 32'h0000_0000, 32'h0000_0000, -1, pds_pkg::StOk, 1'b0);
   endfunction

   // ---------------------------------------------------------------
   // main flow
   // ---------------------------------------------------------------

   initial begin
      int          ph;
      int          stop_at;
      logic [15:0] lim;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      req_tag_n   = -1;
      req_tag_rsp = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, poll limit writes only once the sequencer is idle
      build_table();
      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            settle_idle();
            write_limit(dir_tab[i].csr_val);
         end else begin
            send_beat(dir_tab[i].beat, dir_tab[i].n_typed, dir_tab[i].typed);
         end
      end

      // random part: a few poll limits, mostly well-formed power-ups
      for (ph = 0; ph < NumPhases; ph++) begin
         settle_idle();
         case (ph)
            0: lim = 16'd1;
            1: lim = 16'd0;
            2: lim = 16'hFFFF;
            3: lim = 16'($urandom_range(2, 8));
            4: lim = 16'($urandom_range(9, 65535));
            5: lim = 16'd3;
            default: lim = 16'($urandom_range(1, 20));
         endcase
         write_limit(lim);
         // receiver holds off while the sender keeps offering, so the block backs up
         if (ph == 3) hold_left = HoldCycles;
         stop_at = beats_sent + PhaseBeats;
         while (beats_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else run_power_up();
            // sender pauses until every owed result has come
            if ($urandom_range(0, 11) == 0) drain();
         end
      end

      drain();
      if (exp_rsp.size() > 0) report_err("rsp beats left over", '0, exp_rsp.size());
      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
